// File: sv/lrupr_pkg.sv
// package for the lru page replacement block: sizes, payload structs
// no dependencies; used by lrupr_core and lru_page_replacement
package lrupr_pkg;

    localparam int FRAMES    = 4;
    localparam int PAGE_BITS = 16;
    localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W    = FRAME_W;

    localparam logic ACT_REFERENCE = 1'b0;
    localparam logic ACT_CLEAR     = 1'b1;

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [FRAME_W-1:0]   frame_t;
    typedef logic [RANK_W-1:0]    rank_t;

    typedef struct packed {
        logic        action;
        logic [15:0] page_number;
    } req_t;

    typedef struct packed {
        logic        page_fault;
        logic [1:0]  frame_index;
        logic        evicted_valid;
        logic [15:0] evicted_page;
        logic [15:0] fault_total;
    } rsp_t;

endpackage

// File: sv/lru_page_replacement.sv
// lru page replacement: request register, lookup/update core, result register
// one beat per cycle sustained while rsp_stall stays low; a stalled result holds the request register
// throughput rests on the combinational tag compare and rank update in lrupr_core
// rst_n (async, active low) empties all frames, zeroes ranks and the fault count
// depends on lrupr_pkg and lrupr_core
module lru_page_replacement (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  lrupr_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output lrupr_pkg::rsp_t rsp
);

    logic            in_valid_reg;
    logic            in_valid_next;
    lrupr_pkg::req_t in_item_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    lrupr_pkg::rsp_t out_item_reg;
    lrupr_pkg::rsp_t core_result;
    logic            advance;
    logic            accept;

    // held beat moves on whenever the result slot is empty or draining
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    lrupr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= req;
        end
        if (advance)
        begin
            out_item_reg <= core_result;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

endmodule

// File: sv/lrupr_core.sv
// frame table, recency ranks and fault counter with the combinational lookup/update
// depends on lrupr_pkg
module lrupr_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  lrupr_pkg::req_t item,
    output lrupr_pkg::rsp_t result
);

    lrupr_pkg::page_t frame_page_reg  [lrupr_pkg::FRAMES];
    lrupr_pkg::page_t frame_page_next [lrupr_pkg::FRAMES];
    lrupr_pkg::rank_t rank_reg        [lrupr_pkg::FRAMES];
    lrupr_pkg::rank_t rank_next       [lrupr_pkg::FRAMES];
    logic [lrupr_pkg::FRAMES-1:0] valid_reg;
    logic [lrupr_pkg::FRAMES-1:0] valid_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;

    lrupr_pkg::page_t  pg;
    logic              hit;
    logic              found_empty;
    lrupr_pkg::frame_t hit_f;
    lrupr_pkg::frame_t empty_f;
    lrupr_pkg::frame_t victim_f;
    lrupr_pkg::frame_t f;
    lrupr_pkg::rank_t  old_rank;

    assign pg = lrupr_pkg::PAGE_BITS'(item.page_number);

    // priority picks: first matching frame, first empty frame, oldest frame
    always_comb
    begin
        hit         = 1'b0;
        found_empty = 1'b0;
        hit_f       = '0;
        empty_f     = '0;
        victim_f    = '0;
        for (int j = lrupr_pkg::FRAMES - 1; j >= 0; j--)
        begin
            if (valid_reg[j] && frame_page_reg[j] == pg)
            begin
                hit   = 1'b1;
                hit_f = lrupr_pkg::FRAME_W'(j);
            end
            if (!valid_reg[j])
            begin
                found_empty = 1'b1;
                empty_f     = lrupr_pkg::FRAME_W'(j);
            end
            // full table holds distinct ranks, so the oldest has the top rank
            if (rank_reg[j] == lrupr_pkg::RANK_W'(lrupr_pkg::FRAMES - 1))
            begin
                victim_f = lrupr_pkg::FRAME_W'(j);
            end
        end
    end

    always_comb
    begin
        f = hit ? hit_f : (found_empty ? empty_f : victim_f);
        old_rank = rank_reg[f];

        valid_next = valid_reg;
        count_next = count_reg;
        for (int j = 0; j < lrupr_pkg::FRAMES; j++)
        begin
            frame_page_next[j] = frame_page_reg[j];
            rank_next[j]       = rank_reg[j];
        end
        result = '0;

        if (item.action == lrupr_pkg::ACT_CLEAR)
        begin
            valid_next = '0;
            count_next = '0;
            for (int j = 0; j < lrupr_pkg::FRAMES; j++)
            begin
                rank_next[j] = '0;
            end
        end
        else
        begin
            for (int j = 0; j < lrupr_pkg::FRAMES; j++)
            begin
                if (lrupr_pkg::FRAME_W'(j) == f)
                begin
                    rank_next[j] = '0;
                end
                else if (valid_reg[j] && ((!hit && found_empty) || rank_reg[j] < old_rank))
                begin
                    rank_next[j] = rank_reg[j] + 1'b1;
                end
            end
            if (!hit)
            begin
                valid_next[f]      = 1'b1;
                frame_page_next[f] = pg;
                if (count_reg != 16'hFFFF)
                begin
                    count_next = count_reg + 16'd1;
                end
            end
            result.page_fault    = !hit;
            result.frame_index   = 2'(f);
            result.evicted_valid = !hit && !found_empty;
            result.evicted_page  = (!hit && !found_empty) ? 16'(frame_page_reg[f]) : 16'd0;
            result.fault_total   = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int j = 0; j < lrupr_pkg::FRAMES; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else if (fire)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int j = 0; j < lrupr_pkg::FRAMES; j++)
            begin
                rank_reg[j] <= rank_next[j];
            end
        end
    end

    // page storage carries no reset: only valid frames are ever compared or read
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int j = 0; j < lrupr_pkg::FRAMES; j++)
            begin
                frame_page_reg[j] <= frame_page_next[j];
            end
        end
    end

endmodule

// File: verif/lru_checker.sv
`timescale 1ns / 100ps
// checker for lru_page_replacement: watches both channels, predicts each result
// with its own lru frame table and compares field by field; depends on lrupr_pkg
module lru_checker
    import lrupr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding,
    output int   refs_hit,
    output int   refs_faulted,
    output int   pages_evicted,
    output int   clears_seen
);

    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    // keep the log readable if the block goes badly wrong
    localparam int          MAX_REPORTS = 100;

    page_t       held_page [FRAMES];
    logic        held_valid[FRAMES];
    int          age       [FRAMES];
    logic [15:0] fault_count;
    rsp_t        pending_results[$];
    int          fail_total;
    int          hit_total;
    int          fault_total_seen;
    int          evict_total;
    int          clear_total;

    function automatic void forget_frames();
        int j;
        for (j = 0; j < FRAMES; j++)
        begin
            held_valid[j] = 1'b0;
            held_page[j]  = '0;
            age[j]        = 0;
        end
        fault_count = '0;
    endfunction

    // slot becomes most recent; frames younger than its old rank age by one
    function automatic void promote(input int slot, input int old_rank);
        int j;
        for (j = 0; j < FRAMES; j++)
        begin
            if (j != slot && held_valid[j] && age[j] < old_rank)
                age[j]++;
        end
        age[slot] = 0;
    endfunction

    function automatic rsp_t lru_lookup(input req_t beat);
        rsp_t  res;
        page_t pg;
        int    j;
        int    slot;
        int    oldest;
        logic  hit;
        logic  found_empty;
        res = '0;
        if (beat.action == ACT_CLEAR)
        begin
            forget_frames();
            clear_total++;
            return res;
        end
        pg   = page_t'(beat.page_number);
        hit  = 1'b0;
        slot = 0;
        for (j = 0; j < FRAMES; j++)
        begin
            if (!hit && held_valid[j] && held_page[j] == pg)
            begin
                hit  = 1'b1;
                slot = j;
            end
        end
        if (hit)
        begin
            promote(slot, age[slot]);
            hit_total++;
        end
        else
        begin
            res.page_fault = 1'b1;
            fault_total_seen++;
            found_empty = 1'b0;
            for (j = 0; j < FRAMES; j++)
            begin
                if (!found_empty && !held_valid[j])
                begin
                    found_empty = 1'b1;
                    slot        = j;
                end
            end
            if (found_empty)
            begin
                held_valid[slot] = 1'b1;
                held_page[slot]  = pg;
                promote(slot, FRAMES);
            end
            else
            begin
                // oldest rank wins, lowest frame on a tie
                oldest = 0;
                slot   = 0;
                for (j = 0; j < FRAMES; j++)
                begin
                    if (age[j] > oldest)
                    begin
                        oldest = age[j];
                        slot   = j;
                    end
                end
                res.evicted_valid = 1'b1;
                res.evicted_page  = 16'(held_page[slot]);
                held_page[slot]   = pg;
                promote(slot, age[slot]);
                evict_total++;
            end
            if (fault_count != COUNT_MAX)
                fault_count++;
        end
        res.frame_index = 2'(slot);
        res.fault_total = fault_count;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            fail_total++;
            if (fail_total <= MAX_REPORTS)
                $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            forget_frames();
            pending_results.delete();
            fail_total       = 0;
            hit_total        = 0;
            fault_total_seen = 0;
            evict_total      = 0;
            clear_total      = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= MAX_REPORTS)
                        $error("result beat with no request waiting: %h", rsp);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("page_fault", 16'(want.page_fault),
                                16'(rsp.page_fault));
                    check_field("frame_index", 16'(want.frame_index),
                                16'(rsp.frame_index));
                    check_field("evicted_valid", 16'(want.evicted_valid),
                                16'(rsp.evicted_valid));
                    check_field("evicted_page", want.evicted_page, rsp.evicted_page);
                    check_field("fault_total", want.fault_total, rsp.fault_total);
                end
            end
            if (req_valid && !req_stall)
                pending_results.push_back(lru_lookup(req));
        end
        mismatches    <= fail_total;
        outstanding   <= pending_results.size();
        refs_hit      <= hit_total;
        refs_faulted  <= fault_total_seen;
        pages_evicted <= evict_total;
        clears_seen   <= clear_total;
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// top of the lru_page_replacement testbench: clock, reset, request stimulus,
// result stall pattern and verdict; depends on lrupr_pkg and lru_checker
module testbench;

    import lrupr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 6;
    // back-to-back misses over a working set one larger than the frame count
    localparam int MISS_BEATS     = 24;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    int mismatches;
    int outstanding;
    int refs_hit;
    int refs_faulted;
    int pages_evicted;
    int clears_seen;

    bit sender_idles   = 1'b0;
    bit receiver_idles = 1'b0;
    bit hold_pending   = 1'b0;
    int beats_sent     = 0;
    int quiet_cycles   = 0;

    always #5 clk = ~clk;

    lru_page_replacement u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    lru_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .refs_hit      (refs_hit),
        .refs_faulted  (refs_faulted),
        .pages_evicted (pages_evicted),
        .clears_seen   (clears_seen)
    );

    // nothing accepted on either channel for too long means the block hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side: random stall bursts, free stretches, one long hold-off
    initial
    begin
        int span;
        span = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (span > 0)
                span--;
            else if (hold_pending)
            begin
                hold_pending = 1'b0;
                rsp_stall <= 1'b1;
                span = HOLD_CYCLES - 1;
            end
            else if (receiver_idles && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                span = $urandom_range(0, 9);
            end
            else
            begin
                rsp_stall <= 1'b0;
                span = $urandom_range(0, 19);
            end
        end
    end

    task automatic offer(input logic act, input logic [15:0] page);
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{action: act, page_number: page};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // references drawn mostly from a small working set so that hits, fills
    // and evictions all occur; the rest are stray pages, near misses, clears
    task automatic random_traffic(input int count);
        logic [15:0] pool[8];
        int          pool_size;
        int          k;
        int          i;
        int          pick;
        pool_size = 4;
        for (k = 0; k < count; k++)
        begin
            if (k % 100 == 0)
            begin
                pool_size = $urandom_range(2, 8);
                for (i = 0; i < 8; i++)
                    pool[i] = 16'($urandom);
                if ($urandom_range(0, 1) == 0)
                    pool[0] = 16'h0000;
                if ($urandom_range(0, 1) == 0)
                    pool[1] = 16'hFFFF;
            end
            pick = $urandom_range(0, 99);
            if (pick == 0)
                offer(ACT_CLEAR, 16'($urandom));
            else if (pick < 8)
                offer(ACT_REFERENCE, 16'($urandom));
            else if (pick < 12)
                offer(ACT_REFERENCE, pool[$urandom_range(0, pool_size - 1)]
                                     ^ (16'h1 << $urandom_range(0, 15)));
            else
                offer(ACT_REFERENCE, pool[$urandom_range(0, pool_size - 1)]);
        end
    endtask

    initial
    begin
        int k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fills, hits, lru eviction, clears, extreme page numbers
        offer(ACT_REFERENCE, 16'h0000);
        offer(ACT_REFERENCE, 16'hFFFF);
        offer(ACT_REFERENCE, 16'h0000);
        offer(ACT_REFERENCE, 16'h5555);
        offer(ACT_REFERENCE, 16'hAAAA);
        offer(ACT_REFERENCE, 16'h1234);
        offer(ACT_REFERENCE, 16'hAAAA);
        offer(ACT_REFERENCE, 16'h0001);
        offer(ACT_REFERENCE, 16'h0000);
        offer(ACT_REFERENCE, 16'h8000);
        offer(ACT_CLEAR,     16'hFFFF);
        offer(ACT_CLEAR,     16'h0000);
        offer(ACT_REFERENCE, 16'hFFFF);
        offer(ACT_REFERENCE, 16'hFFFE);
        offer(ACT_REFERENCE, 16'h7FFF);
        offer(ACT_REFERENCE, 16'h8000);
        offer(ACT_REFERENCE, 16'hFFFF);
        offer(ACT_REFERENCE, 16'h0000);
        offer(ACT_REFERENCE, 16'hFFFE);
        offer(ACT_REFERENCE, 16'h7FFF);
        offer(ACT_REFERENCE, 16'h8000);
        offer(ACT_CLEAR,     16'h5A5A);

        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        random_traffic(500);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        random_traffic(100);
        // long result hold-off while requests keep coming
        hold_pending = 1'b1;
        random_traffic(100);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        random_traffic(1100);

        // last part, back to back: five pages over four frames always miss,
        // so after the four fills every beat evicts the least recently used page
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        offer(ACT_CLEAR, 16'h0000);
        for (k = 0; k < MISS_BEATS; k++)
            offer(ACT_REFERENCE, 16'hF000 + 16'(k % 5));
        offer(ACT_REFERENCE, 16'(16'hF000 + (MISS_BEATS - 1) % 5));
        offer(ACT_REFERENCE, 16'hC0DE);
        offer(ACT_CLEAR, 16'hFFFF);
        offer(ACT_REFERENCE, 16'h0042);

        req_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d request beats: %0d hits, %0d faults, %0d evictions, %0d clears",
                 beats_sent, refs_hit, refs_faulted, pages_evicted, clears_seen);
        $display("ended on a back-to-back miss run; result side held off %0d cycles once",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
